>>> hw/rtl/rme_pkg.sv
`timescale 1ns / 1ps

package rme_pkg;

    localparam int FRAC_IN   = 14;
    localparam int ANG_FRAC  = 30;
    localparam int OUT_FRAC  = 13;
    localparam int ITER      = 16;
    localparam int SCALE_SH  = ANG_FRAC - FRAC_IN;
    localparam int CW        = ANG_FRAC + 4;
    localparam int SQ_STEPS  = FRAC_IN + 1;
    localparam int SQW       = 2 * FRAC_IN + 2;
    localparam int OUT_SH    = ANG_FRAC - OUT_FRAC;
    localparam int ENT_W     = 16;
    localparam int ROOT_W    = FRAC_IN + 1;

    localparam logic signed [ENT_W-1:0] ONE_Q     = ENT_W'(1 << FRAC_IN);
    localparam logic signed [CW-1:0]    HALF_PI_Q = CW'(64'sd1686629713);
    localparam logic signed [15:0]      HALF_PI_OUT = 16'sd12868;
    localparam logic signed [15:0]      OUT_LIMIT   = 16'sd25736;

    typedef logic signed [ENT_W:0] ent_t;
    typedef logic signed [CW-1:0]  ang_t;

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2
    } pole_t;

    function automatic ang_t atan_val(input int i);
        logic [31:0] v;
        begin
            case (i)
                0:  v = 32'd843314856;
                1:  v = 32'd497837829;
                2:  v = 32'd263043836;
                3:  v = 32'd133525158;
                4:  v = 32'd67021686;
                5:  v = 32'd33543515;
                6:  v = 32'd16775850;
                7:  v = 32'd8388437;
                8:  v = 32'd4194282;
                9:  v = 32'd2097149;
                10: v = 32'd1048575;
                11: v = 32'd524287;
                12: v = 32'd262143;
                13: v = 32'd131071;
                14: v = 32'd65535;
                15: v = 32'd32767;
                16: v = 32'd16383;
                17: v = 32'd8191;
                18: v = 32'd4095;
                19: v = 32'd2047;
                20: v = 32'd1023;
                21: v = 32'd511;
                22: v = 32'd255;
                23: v = 32'd127;
                default: v = 32'd0;
            endcase
            atan_val = CW'(v);
        end
    endfunction

    // round half away from zero to the output format, then clamp
    function automatic logic signed [15:0] to_out(input ang_t a);
        logic [CW-1:0] mag;
        logic [CW-1:0] r;
        logic signed [15:0] q;
        begin
            mag = a[CW-1] ? CW'(-a) : CW'(a);
            r   = (mag + (CW'(1) << (OUT_SH - 1))) >> OUT_SH;
            if (r > CW'(OUT_LIMIT))
                q = OUT_LIMIT;
            else
                q = 16'(r);
            to_out = a[CW-1] ? -q : q;
        end
    endfunction

endpackage

>>> hw/rtl/rme_isqrt.sv
`timescale 1ns / 1ps

module rme_isqrt
    import rme_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQW-1:0]    v,
    output logic [ROOT_W-1:0] root
);

    logic [SQW-1:0] v_reg   [0:SQ_STEPS-1];
    logic [SQW-1:0] res_reg [0:SQ_STEPS-1];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_step
            localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
            logic [SQW-1:0] v_in;
            logic [SQW-1:0] res_in;
            if (k == 0) begin : g_first
                assign v_in   = v;
                assign res_in = '0;
            end
            else begin : g_next
                assign v_in   = v_reg[k-1];
                assign res_in = res_reg[k-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (v_in >= res_in + BIT)
                    begin
                        v_reg[k]   <= v_in - (res_in + BIT);
                        res_reg[k] <= (res_in >> 1) + BIT;
                    end
                    else
                    begin
                        v_reg[k]   <= v_in;
                        res_reg[k] <= res_in >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = res_reg[SQ_STEPS-1][ROOT_W-1:0];

endmodule

>>> hw/rtl/rme_cordic.sv
`timescale 1ns / 1ps

module rme_cordic
    import rme_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  ent_t y,
    input  ent_t x,
    output ang_t angle
);

    ang_t x_reg [0:ITER];
    ang_t y_reg [0:ITER];
    ang_t z_reg [0:ITER];

    ang_t xs;
    ang_t ys;

    assign xs = CW'(x) <<< SCALE_SH;
    assign ys = CW'(y) <<< SCALE_SH;

    // fold the left half-plane onto the right one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (xs < 0)
            begin
                if (ys >= 0)
                begin
                    x_reg[0] <= ys;
                    y_reg[0] <= -xs;
                    z_reg[0] <= HALF_PI_Q;
                end
                else
                begin
                    x_reg[0] <= -ys;
                    y_reg[0] <= xs;
                    z_reg[0] <= -HALF_PI_Q;
                end
            end
            else
            begin
                x_reg[0] <= xs;
                y_reg[0] <= ys;
                z_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < ITER; i++) begin : g_iter
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (y_reg[i] > 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + atan_val(i);
                    end
                    else if (y_reg[i] < 0)
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - atan_val(i);
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i];
                        y_reg[i+1] <= y_reg[i];
                        z_reg[i+1] <= z_reg[i];
                    end
                end
            end
        end
    endgenerate

    assign angle = z_reg[ITER];

endmodule

>>> hw/rtl/rotation_matrix_to_euler_top.sv
`timescale 1ns / 1ps

// Rotation matrix to Euler angles. Takes one matrix (seven Q1.14 entries) per
// cycle unless the output stalls, and returns angle_x, angle_y, angle_z in
// Q3.13 radians plus a pole flag. Every matrix passes 36 register stages: the
// input register, the square and 1 - s^2 stages, the 15-step square root, the
// 17-stage CORDIC (fold plus 16 iterations) that computes asin(m10) from s and
// the root, and the output register. A stall on the output freezes the whole
// pipeline. pole_threshold is to be written by the user through cfg_valid/cfg_data
// only while the block idles; the block itself does not enforce this.
module rotation_matrix_to_euler_top
    import rme_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [14:0]  cfg_data,       // pole_threshold
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,   // m00, m02, m10, m11, m12, m20, m22
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // angle_x, angle_y, angle_z
    output logic [1:0]   m_axis_tuser    // pole_case
);

    localparam int D_SIDE = 2 + SQ_STEPS;
    localparam int D_COR  = 1 + ITER;
    localparam int LAT    = 1 + D_SIDE + D_COR + 1;

    typedef struct packed {
        logic signed [ENT_W-1:0] s;
        ent_t                    xy;
        ent_t                    xx;
        ent_t                    zy;
        ent_t                    zx;
        pole_t                   pole;
    } side_t;

    logic [14:0] thr_reg;
    logic        vld_reg [0:LAT-1];
    logic        en;

    side_t side_reg [0:D_SIDE];
    pole_t pole_reg [0:D_COR-1];

    logic signed [ENT_W-1:0] ent [0:6];
    side_t                   side_next;

    logic [SQW-1:0]    sq_reg;
    logic [SQW-1:0]    rem_reg;
    logic [ROOT_W-1:0] root;
    ang_t              ax;
    ang_t              ay;
    ang_t              az;
    logic [47:0]       data_reg;
    pole_t             pole_out_reg;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 15'd16351;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    always_comb
    begin
        for (int e = 0; e < 7; e++)
        begin
            ent[e] = s_axis_tdata[e*ENT_W +: ENT_W];
            if (ent[e] > ONE_Q)
                ent[e] = ONE_Q;
            else if (ent[e] < -ONE_Q)
                ent[e] = -ONE_Q;
        end
    end

    always_comb
    begin
        side_next.s  = ent[2];
        side_next.xy = -ent_t'(ent[4]);
        side_next.xx = ent_t'(ent[3]);
        if (ent_t'(ent[2]) > ent_t'({2'b00, thr_reg}))
            side_next.pole = POLE_NORTH;
        else if (ent_t'(ent[2]) < -ent_t'({2'b00, thr_reg}))
            side_next.pole = POLE_SOUTH;
        else
            side_next.pole = POLE_NONE;
        if (side_next.pole == POLE_NONE)
        begin
            side_next.zy = -ent_t'(ent[5]);
            side_next.zx = ent_t'(ent[0]);
        end
        else
        begin
            side_next.zy = ent_t'(ent[1]);
            side_next.zx = ent_t'(ent[6]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // side register chain, square of m10, then 1 - s^2 for the root pipeline, and the pole delay
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= D_SIDE; k++)
                side_reg[k] <= side_reg[k-1];
            sq_reg <= SQW'(32'(side_reg[0].s * side_reg[0].s));
            if (sq_reg >= (SQW'(1) << (2 * FRAC_IN)))
                rem_reg <= '0;
            else
                rem_reg <= (SQW'(1) << (2 * FRAC_IN)) - sq_reg;
            pole_reg[0] <= side_reg[D_SIDE].pole;
            for (int k = 1; k < D_COR; k++)
                pole_reg[k] <= pole_reg[k-1];
        end
    end

    rme_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .v    (rem_reg),
        .root (root)
    );

    rme_cordic u_cordic_x (
        .clk   (clk),
        .en    (en),
        .y     (side_reg[D_SIDE].xy),
        .x     (side_reg[D_SIDE].xx),
        .angle (ax)
    );

    rme_cordic u_cordic_y (
        .clk   (clk),
        .en    (en),
        .y     (ent_t'(side_reg[D_SIDE].s)),
        .x     (ent_t'({2'b00, root})),
        .angle (ay)
    );

    rme_cordic u_cordic_z (
        .clk   (clk),
        .en    (en),
        .y     (side_reg[D_SIDE].zy),
        .x     (side_reg[D_SIDE].zx),
        .angle (az)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pole_out_reg <= pole_reg[D_COR-1];
            data_reg[47:32] <= to_out(az);
            case (pole_reg[D_COR-1])
                POLE_NORTH:
                begin
                    data_reg[15:0]  <= '0;
                    data_reg[31:16] <= HALF_PI_OUT;
                end
                POLE_SOUTH:
                begin
                    data_reg[15:0]  <= '0;
                    data_reg[31:16] <= -HALF_PI_OUT;
                end
                default:
                begin
                    data_reg[15:0]  <= to_out(ax);
                    data_reg[31:16] <= to_out(ay);
                end
            endcase
        end
    end

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = pole_out_reg;

endmodule

>>> tb/sv/tb_rotation_matrix_to_euler_top.sv
`timescale 1ns / 1ps

module tb_rotation_matrix_to_euler_top;
    import rme_pkg::*;

    localparam int LATENCY     = 36;
    localparam int NUM_RANDOM  = 700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_DIRECTED = 22;
    localparam logic [15:0] NO_CHECK = 16'h7FFF;

    typedef struct packed {
        logic signed [15:0] m22;
        logic signed [15:0] m20;
        logic signed [15:0] m12;
        logic signed [15:0] m11;
        logic signed [15:0] m10;
        logic signed [15:0] m02;
        logic signed [15:0] m00;
    } matrix_t;

    typedef struct packed {
        pole_t              pole;
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } euler_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [14:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;   // angle_x, angle_y, angle_z
    logic [1:0]   m_axis_tuser;   // pole_case

    rotation_matrix_to_euler_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic [14:0] threshold;
    euler_t      pending_angles[$];
    euler_t      typed_angles[$];
    int          errors;
    int          cycles;
    logic        stall_mode;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint clamp_entry(logic signed [15:0] raw);
        longint v;
        v = raw;
        if (v > (1 << FRAC_IN))
            v = 1 << FRAC_IN;
        if (v < -(1 << FRAC_IN))
            v = -(1 << FRAC_IN);
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint steps[24];
        steps = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                  16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                  262143, 131071, 65535, 32767, 16383, 8191,
                  4095, 2047, 1023, 511, 255, 127};
        return steps[i];
    endfunction

    function automatic longint vector_angle(longint y_in, longint x_in);
        longint x, y, z, t, dx, dy;
        x = x_in <<< SCALE_SH;
        y = y_in <<< SCALE_SH;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 1686629713;
            end
            else
            begin
                x = -y; y = t; z = -1686629713;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
            else if (y < 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint floor_root(longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    function automatic logic signed [15:0] round_angle(longint a);
        longint r;
        r = (a >= 0) ? (a + (1 <<< 16)) >>> 17 : -(((-a) + (1 <<< 16)) >>> 17);
        if (r > 25736)
            r = 25736;
        if (r < -25736)
            r = -25736;
        return 16'(r);
    endfunction

    function automatic euler_t predict_angles(matrix_t m);
        euler_t e;
        longint m00, m02, m10, m11, m12, m20, m22, rem;
        m00 = clamp_entry(m.m00); m02 = clamp_entry(m.m02);
        m10 = clamp_entry(m.m10); m11 = clamp_entry(m.m11);
        m12 = clamp_entry(m.m12); m20 = clamp_entry(m.m20);
        m22 = clamp_entry(m.m22);
        if (m10 > longint'(threshold))
        begin
            e.ax = '0; e.ay = HALF_PI_OUT; e.pole = POLE_NORTH;
            e.az = round_angle(vector_angle(m02, m22));
        end
        else if (m10 < -longint'(threshold))
        begin
            e.ax = '0; e.ay = -HALF_PI_OUT; e.pole = POLE_SOUTH;
            e.az = round_angle(vector_angle(m02, m22));
        end
        else
        begin
            rem = (1 << (2 * FRAC_IN)) - m10 * m10;
            if (rem < 0)
                rem = 0;
            e.ax = round_angle(vector_angle(-m12, m11));
            e.ay = round_angle(vector_angle(m10, floor_root(rem)));
            e.az = round_angle(vector_angle(-m20, m00));
            e.pole = POLE_NONE;
        end
        return e;
    endfunction

    // compare output transfers against the oldest expectation
    always @(posedge clk)
    begin
        euler_t got, want, typed;
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {pole_t'(m_axis_tuser), m_axis_tdata};
            if (pending_angles.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
            end
            else
            begin
                want = pending_angles.pop_front();
                typed = typed_angles.pop_front();
                if (got.ax !== want.ax || (typed.ax != NO_CHECK && got.ax !== typed.ax))
                begin
                    $error("angle_x: expected %0d, got %0d", want.ax, got.ax);
                    errors++;
                end
                if (got.ay !== want.ay || (typed.ay != NO_CHECK && got.ay !== typed.ay))
                begin
                    $error("angle_y: expected %0d, got %0d", want.ay, got.ay);
                    errors++;
                end
                if (got.az !== want.az || (typed.az != NO_CHECK && got.az !== typed.az))
                begin
                    $error("angle_z: expected %0d, got %0d", want.az, got.az);
                    errors++;
                end
                if (got.pole !== want.pole)
                begin
                    $error("pole_case: expected %0d, got %0d", want.pole, got.pole);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern: either always ready or stalling in runs
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        m_axis_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_matrix(matrix_t m, euler_t typed);
        s_axis_tdata  <= m;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_angles.push_back(predict_angles(m));
        typed_angles.push_back(typed);
        @(negedge clk);
    endtask

    task automatic write_threshold(logic [14:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        threshold = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_angles.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_entry(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 32768) - 16384);
            default: return 16'($urandom_range(0, 36000) - 18000);
        endcase
    endfunction

    task automatic send_burst(int count);
        matrix_t m;
        euler_t  open_check;
        int      mode;
        int      near;
        open_check = '{pole: POLE_NONE, az: NO_CHECK, ay: NO_CHECK, ax: NO_CHECK};
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 5);
            m.m00 = rand_entry(mode % 3); m.m02 = rand_entry(mode % 3);
            m.m11 = rand_entry(mode % 3); m.m12 = rand_entry(mode % 3);
            m.m20 = rand_entry(mode % 3); m.m22 = rand_entry(mode % 3);
            // aim m10 near the poles part of the time
            if (mode == 5)
            begin
                near = int'($urandom_range(16300, 16380));
                if ($urandom_range(0, 1) != 0)
                    near = -near;
                m.m10 = 16'(near);
            end
            else
                m.m10 = rand_entry(mode % 3);
            send_matrix(m, open_check);
            if ($urandom_range(0, 3) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        matrix_t directed_in[NUM_DIRECTED];
        euler_t  directed_out[NUM_DIRECTED];
        logic [14:0] settings[4];
        int      sent;
        int      count;
        localparam logic signed [15:0] P1 = 16'sd16384;
        localparam logic signed [15:0] N1 = -16'sd16384;
        localparam logic signed [15:0] K  = NO_CHECK;

        clk = 1'b0;
        // m22, m20, m12, m11, m10, m02, m00
        directed_in = '{
            '{P1, 0, 0, P1, 0, 0, P1},
            '{0, 0, 0, 0, 0, 0, 0},
            '{P1, P1, P1, P1, P1, P1, P1},
            '{N1, N1, N1, N1, N1, N1, N1},
            '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
            '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
            '{N1, 0, 0, N1, 0, 0, N1},
            '{P1, 0, 0, P1, 16'sd16351, 0, P1},
            '{P1, 0, 0, P1, 16'sd16352, 0, P1},
            '{P1, 0, 0, P1, -16'sd16351, 0, P1},
            '{P1, 0, 0, P1, -16'sd16352, 0, P1},
            '{0, 0, 0, 0, 16'sd16352, P1, 0},
            '{N1, 0, 0, 0, -16'sd16352, 0, 0},
            '{0, P1, P1, 0, 0, 0, 0},
            '{0, N1, N1, 0, 0, 0, 0},
            '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh2AAA, 16'shD555, 16'sh1234},
            '{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shD555, 16'sh2AAA, 16'shEDCB},
            '{16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1},
            '{-16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1},
            '{16'sd11585, -16'sd11585, 16'sd11585, 16'sd11585, 16'sd8192, 16'sd11585, 16'sd14189},
            '{16'sh4000, 16'shC000, 16'sh3FFF, 16'shC001, 16'sh0100, 16'shFF00, 16'sh7000},
            '{16'sh0F0F, 16'shF0F0, 16'sh00FF, 16'shFF00, 16'sh0001, 16'shFFFE, 16'sh8001}
        };
        for (int i = 0; i < NUM_DIRECTED; i++)
            directed_out[i] = '{pole: POLE_NONE, az: K, ay: K, ax: K};
        directed_out[0] = '{pole: POLE_NONE, az: 0, ay: 0, ax: 0};
        directed_out[1] = '{pole: POLE_NONE, az: 0, ay: 0, ax: 0};
        directed_out[8] = '{pole: POLE_NORTH, az: 0, ay: HALF_PI_OUT, ax: 0};
        directed_out[10] = '{pole: POLE_SOUTH, az: 0, ay: -HALF_PI_OUT, ax: 0};

        settings = '{15'd16384, 15'd0, 15'd8000, 15'd16383};
        errors = 0;
        cycles = 0;
        stall_mode = 1'b0;
        threshold = 15'd16351;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_matrix(directed_in[i], directed_out[i]);
        s_axis_tvalid <= 1'b0;
        drain();

        sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
                write_threshold(settings[phase - 1]);
            while (sent < (phase + 1) * NUM_RANDOM / 5)
            begin
                count = $urandom_range(1, 30);
                send_burst(count);
                sent = sent + count;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            for (int k = 0; k < NUM_DIRECTED; k++)
                send_matrix(directed_in[k], '{pole: POLE_NONE, az: K, ay: K, ax: K});
            s_axis_tvalid <= 1'b0;
            drain();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
